>>> rtl/tea_pkg.sv
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and the round mixing function of the TEA cipher.
// ----------------------------------------------------------------------------
package tea_pkg;

	localparam logic [31:0] DELTA = 32'h9e37_79b9;

	localparam logic DIR_ENC = 1'b0;
	localparam logic DIR_DEC = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [31:0] block_left;
		logic [31:0] block_right;
	} in_t;

	typedef struct packed {
		logic [31:0] out_left;
		logic [31:0] out_right;
	} out_t;

	typedef struct packed {
		logic        dir;
		logic [31:0] y;
		logic [31:0] z;
	} stage_t;

	typedef struct packed {
		logic [31:0] k0;
		logic [31:0] k1;
		logic [31:0] k2;
		logic [31:0] k3;
	} key_t;

	function automatic logic [31:0] tea_mix(input logic [31:0] v, input logic [31:0] sum,
			input logic [31:0] ka, input logic [31:0] kb);
		tea_mix = ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
	endfunction

endpackage

>>> rtl/tea_stage.sv
// ----------------------------------------------------------------------------
// tea_stage
// One registered half-round. Even stages update the first half of the
// round, odd stages the second; the round's sum is fixed per stage and direction.
// ----------------------------------------------------------------------------
module tea_stage import tea_pkg::*; #(
	parameter int ROUNDS = 32,
	parameter int STAGE  = 0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  key_t   key,
	input  logic   valid_in,
	input  stage_t data_in,
	output logic   valid_out,
	output stage_t data_out
);

	localparam int unsigned RND     = STAGE / 2;
	localparam bit          ODD     = (STAGE % 2) == 1;
	localparam logic [31:0] SUM_ENC = DELTA * 32'(RND + 1);
	localparam logic [31:0] SUM_DEC = DELTA * 32'(ROUNDS - RND);

	logic        valid_s1;
	stage_t      data_s1;
	stage_t      nxt;
	logic [31:0] mix_y;
	logic [31:0] mix_z;
	logic [31:0] sum;

	always_comb begin
		sum   = (data_in.dir == DIR_DEC) ? SUM_DEC : SUM_ENC;
		mix_y = tea_mix(data_in.z, sum, key.k0, key.k1);
		mix_z = tea_mix(data_in.y, sum, key.k2, key.k3);
		nxt   = data_in;
		if (data_in.dir == DIR_ENC) begin
			if (ODD) nxt.z = data_in.z + mix_z;
			else     nxt.y = data_in.y + mix_y;
		end else begin
			if (ODD) nxt.y = data_in.y - mix_y;
			else     nxt.z = data_in.z - mix_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign valid_out = valid_s1;
	assign data_out  = data_s1;

endmodule

>>> rtl/tea_block_cipher.sv
// ----------------------------------------------------------------------------
// tea_block_cipher
// TEA 64-bit block cipher, 128-bit key, fully pipelined.
//
// Key words 0..3 are written over the APB port at byte addresses 0, 4, 8, 12
// and read back there. Write the key only while no block is in flight.
// Input beats carry req_type (0 encrypt, 1 decrypt) and the two halves; each
// beat yields one output beat with the transformed halves, in order.
// The pipeline has one register stage per half-round, 2*ROUNDS stages, then
// an output register, and a new block is taken every cycle while in_ready
// is high.
// Reset clears the key words and all valid bits.
// When the receiver stalls, a two-entry output buffer absorbs the beat in
// flight; once it is full the whole pipeline holds and in_ready drops until
// the buffer drains. No beat is lost or repeated.
// ----------------------------------------------------------------------------
module tea_block_cipher import tea_pkg::*; #(
	parameter int ROUNDS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data
);

	localparam int NSTG = 2 * ROUNDS;

	key_t   key_q;
	logic   en;
	logic   pipe_valid [NSTG+1];
	stage_t pipe_data  [NSTG+1];
	logic   out_valid_q;
	out_t   out_q;
	logic   skid_valid_q;
	out_t   skid_q;
	logic   take;
	logic   push;
	out_t   last;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				2'd0:    key_q.k0 <= pwdata;
				2'd1:    key_q.k1 <= pwdata;
				2'd2:    key_q.k2 <= pwdata;
				2'd3:    key_q.k3 <= pwdata;
				default: key_q    <= key_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			2'd0:    prdata = key_q.k0;
			2'd1:    prdata = key_q.k1;
			2'd2:    prdata = key_q.k2;
			2'd3:    prdata = key_q.k3;
			default: prdata = '0;
		endcase
	end

	assign en       = !skid_valid_q;
	assign in_ready = en;

	assign pipe_valid[0]     = in_valid;
	assign pipe_data[0].dir  = in_data.req_type;
	assign pipe_data[0].y    = in_data.block_left;
	assign pipe_data[0].z    = in_data.block_right;

	for (genvar i = 0; i < NSTG; i++) begin : g_stage
		tea_stage #(
			.ROUNDS(ROUNDS),
			.STAGE (i)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.key      (key_q),
			.valid_in (pipe_valid[i]),
			.data_in  (pipe_data[i]),
			.valid_out(pipe_valid[i+1]),
			.data_out (pipe_data[i+1])
		);
	end

	assign last.out_left  = pipe_data[NSTG].y;
	assign last.out_right = pipe_data[NSTG].z;
	assign take = out_ready || !out_valid_q;
	assign push = pipe_valid[NSTG] && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) out_q <= skid_q;
			else if (push)    out_q <= last;
		end else if (push) begin
			skid_q <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> tb/tea_block_cipher_test.sv
// ----------------------------------------------------------------------------
// tea_block_cipher_test
// Self-checking testbench for the TEA block cipher. Key words go in over APB
// while the pipeline is empty and are read back. Blocks are streamed through
// a valid/ready driver with random gaps and output stalls, and each output
// beat is compared with an in-order queue of ciphertexts and plaintexts
// computed here. Encrypt/decrypt pairs chain the predicted result into the
// next beat so that both directions are run over the same data.
// ----------------------------------------------------------------------------
module tea_block_cipher_test import tea_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ROUNDS    = 32;
	localparam int NUM_KEYS    = 4;
	localparam int KEY0_IDX    = 0;
	localparam int KEY1_IDX    = 1;
	localparam int KEY2_IDX    = 2;
	localparam int KEY3_IDX    = 3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_LIMIT = 40;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [3:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_t         in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_t        out_data;

	logic [31:0] key_words [NUM_KEYS];
	in_t         pending_blocks [$];
	out_t        cipher_due [$];
	logic        in_taken    = 1'b0;
	int          send_pct    = 0;
	int          recv_pct    = 0;
	int          send_gap    = 0;
	int          recv_gap    = 0;
	int          error_count = 0;
	int          cycle_count = 0;

	tea_block_cipher #(
		.ROUNDS(N_ROUNDS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #6 clk = ~clk;

	function automatic logic [31:0] half_round_mix(input logic [31:0] v, input logic [31:0] sum,
			input logic [31:0] ka, input logic [31:0] kb);
		return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
	endfunction

	function automatic out_t cipher_result(input in_t blk);
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] sum;
		out_t        res;
		y = blk.block_left;
		z = blk.block_right;
		if (blk.req_type == DIR_ENC) begin
			sum = '0;
			repeat (N_ROUNDS) begin
				sum = sum + DELTA;
				y = y + half_round_mix(z, sum, key_words[KEY0_IDX], key_words[KEY1_IDX]);
				z = z + half_round_mix(y, sum, key_words[KEY2_IDX], key_words[KEY3_IDX]);
			end
		end else begin
			sum = DELTA * N_ROUNDS;
			repeat (N_ROUNDS) begin
				z = z - half_round_mix(y, sum, key_words[KEY2_IDX], key_words[KEY3_IDX]);
				y = y - half_round_mix(z, sum, key_words[KEY0_IDX], key_words[KEY1_IDX]);
				sum = sum - DELTA;
			end
		end
		res.out_left  = y;
		res.out_right = z;
		return res;
	endfunction

	function automatic logic [31:0] rand_word();
		int bitpos;
		bitpos = $urandom_range(0, 31);
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			2: begin
				return 32'h1 << bitpos;
			end
			3: begin
				return ~(32'h1 << bitpos);
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (error_count < PRINT_LIMIT)
			$display("%0t: %s: got %08h, want %08h", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic apb_write(input int idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 4'(idx * 4);
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		key_words[idx] = val;
	endtask

	task automatic apb_check(input int idx);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= 4'(idx * 4);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== key_words[idx])
			report_mismatch($sformatf("key word %0d readback", idx), prdata, key_words[idx]);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_keys(input key_t k);
		apb_write(KEY0_IDX, k.k0);
		apb_write(KEY1_IDX, k.k1);
		apb_write(KEY2_IDX, k.k2);
		apb_write(KEY3_IDX, k.k3);
		for (int i = 0; i < NUM_KEYS; i++)
			apb_check(i);
	endtask

	// rates are changed right after a rising edge, away from the driving edge
	task automatic set_idling(input int sp, input int rp);
		@(posedge clk);
		send_pct = sp;
		recv_pct = rp;
	endtask

	task automatic push_block(input logic dir, input logic [31:0] l, input logic [31:0] r);
		in_t blk;
		blk.req_type    = dir;
		blk.block_left  = l;
		blk.block_right = r;
		pending_blocks.push_back(blk);
	endtask

	task automatic push_pair(input logic dir, input logic [31:0] l, input logic [31:0] r);
		in_t  blk;
		out_t res;
		blk.req_type    = dir;
		blk.block_left  = l;
		blk.block_right = r;
		res = cipher_result(blk);
		pending_blocks.push_back(blk);
		push_block(~dir, res.out_left, res.out_right);
	endtask

	task automatic push_edges();
		push_block(DIR_ENC, 32'h0000_0000, 32'h0000_0000);
		push_block(DIR_DEC, 32'h0000_0000, 32'h0000_0000);
		push_block(DIR_ENC, 32'hffff_ffff, 32'hffff_ffff);
		push_block(DIR_DEC, 32'hffff_ffff, 32'hffff_ffff);
		push_block(DIR_ENC, 32'h0000_0001, 32'h8000_0000);
		push_block(DIR_DEC, 32'h8000_0000, 32'h0000_0001);
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (pending_blocks.size() != 0 || in_valid || cipher_due.size() != 0);
	endtask

	always @(negedge clk) begin : driver
		if (!in_valid || in_taken) begin
			if (send_gap == 0 && pending_blocks.size() != 0 && $urandom_range(0, 99) < send_pct)
				send_gap = $urandom_range(1, 5);
			if (send_gap != 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_blocks.size() != 0) begin
				in_data  <= pending_blocks.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (recv_gap == 0 && $urandom_range(0, 99) < recv_pct)
			recv_gap = $urandom_range(1, 5);
		if (recv_gap != 0) begin
			recv_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : monitor
		out_t want;
		in_taken <= in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			if (cipher_due.size() == 0) begin
				report_mismatch("output beat with nothing pending", out_data.out_left, '0);
			end else begin
				want = cipher_due.pop_front();
				if (out_data.out_left !== want.out_left)
					report_mismatch("out_left", out_data.out_left, want.out_left);
				if (out_data.out_right !== want.out_right)
					report_mismatch("out_right", out_data.out_right, want.out_right);
			end
		end
		if (arst_n && in_valid && in_ready)
			cipher_due.push_back(cipher_result(in_data));
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : stimulus
		key_t keys;
		int   count;
		for (int i = 0; i < NUM_KEYS; i++)
			key_words[i] = '0;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// reset key, then all-ones key, then mixed extremes
		for (int i = 0; i < NUM_KEYS; i++)
			apb_check(i);
		set_idling(0, 0);
		push_edges();
		drain();

		load_keys('1);
		set_idling(0, 0);
		push_edges();
		push_pair(DIR_ENC, 32'h0123_4567, 32'h89ab_cdef);
		drain();

		keys = {32'h0000_0000, 32'hffff_ffff, 32'haaaa_aaaa, 32'h5555_5555};
		load_keys(keys);
		set_idling(0, 0);
		push_edges();
		push_pair(DIR_DEC, 32'hdead_beef, 32'h0bad_f00d);
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			keys = {rand_word(), rand_word(), rand_word(), rand_word()};
			load_keys(keys);
			case (phase % 4)
				0: set_idling(0, 0);
				1: set_idling(20, 20);
				2: set_idling(5, 60);
				default: set_idling(50, 10);
			endcase
			if (phase == 7)
				set_idling(0, 0);
			count = 0;
			while (count < 250) begin
				if ($urandom_range(0, 2) == 0) begin
					push_pair(1'($urandom_range(0, 1)), rand_word(), rand_word());
					count += 2;
				end else begin
					push_block(1'($urandom_range(0, 1)), rand_word(), rand_word());
					count++;
				end
			end
			drain();
		end

		repeat (2 * N_ROUNDS + 16) @(negedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
